// ----- rtl/igfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_pkg: shared types and constants for the information gain block
// Field widths, operation and status codes, controller command and status
// bundles, and small helper functions.
// ----------------------------------------------------------------------------
package igfc_pkg;

    // Parameter defaults
    localparam int MAX_LABELS_DEF      = 16;
    localparam int MAX_ATTR_VALUES_DEF = 16;
    localparam int COUNT_BITS_DEF      = 24;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 24;
    localparam int OUT_W  = 20;
    localparam int ST_W   = 2;

    // Internal widths
    localparam int WORD_W = 32;
    localparam int EXP_W  = 5;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = EXP_W + FRAC_W;
    localparam int ACC_W  = 64;
    localparam int STEP_W = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LABEL   = 2'd0,
        OP_ATTR    = 2'd1,
        OP_JOINT   = 2'd2,
        OP_COMPUTE = 2'd3
    } t_op;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_TOTAL = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_ATTR    = 2'd2;

    // Operand source of the log2 unit
    typedef enum logic [1:0] {
        SRC_LABEL = 2'd0,
        SRC_TOTAL = 2'd1,
        SRC_ATTR  = 2'd2,
        SRC_JOINT = 2'd3
    } t_log_src;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     latch_n;
        logic     log_start;
        t_log_src log_src;
        logic     cap_la;
        logic     cap_lb;
        logic     cap_ln;
        logic     cap_op;
        logic     mul_pair;
        logic     acc_s;
        logic     acc_c;
        logic     div_start;
        logic     div_c;
        logic     cap_q;
        logic     cap_hc;
        logic     zero_hc;
        logic     set_st2;
        logic     rd_pair;
        logic     emit;
        logic     clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic n_zero;
        logic lbl_nz;
        logic v_zero;
        logic a_zero;
        logic log_done;
        logic div_done;
        logic c_pos;
    } t_stat;

    // Position of the leading one (zero for a zero word)
    function automatic logic [EXP_W-1:0] msb_pos(logic [WORD_W-1:0] x);
        logic [EXP_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) pos = EXP_W'(i);
        end
        return pos;
    endfunction

    // Saturate to the output range
    function automatic logic [OUT_W-1:0] sat_out(logic [ACC_W-1:0] v);
        return (v > ACC_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/igfc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module igfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/igfc_log2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_log2: iterative base-2 logarithm
// Integer part from leading-one detection, 16 fraction bits from repeated
// squaring of the Q1.31 mantissa, one squaring per cycle.
// ----------------------------------------------------------------------------
module igfc_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [igfc_pkg::WORD_W-1:0] i_x,
    output logic                       o_done,
    output logic [igfc_pkg::LOG_W-1:0] o_result
);

    logic                         r_busy;
    logic                         r_done;
    logic [igfc_pkg::STEP_W-1:0]  r_cnt;
    logic [igfc_pkg::EXP_W-1:0]   r_e;
    logic [igfc_pkg::FRAC_W-1:0]  r_frac;
    logic [igfc_pkg::WORD_W-1:0]  r_m;

    logic [igfc_pkg::EXP_W-1:0]     w_e;
    logic [2*igfc_pkg::WORD_W-1:0]  w_sq;
    logic [igfc_pkg::WORD_W:0]      w_t;

    assign w_e  = igfc_pkg::msb_pos(i_x);
    assign w_sq = (2*igfc_pkg::WORD_W)'(r_m) * (2*igfc_pkg::WORD_W)'(r_m);
    assign w_t  = w_sq[2*igfc_pkg::WORD_W-1:igfc_pkg::WORD_W-1];

    // Normalize on start, then square once per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_e    <= w_e;
                r_frac <= '0;
                r_m    <= i_x << (igfc_pkg::EXP_W'(igfc_pkg::WORD_W - 1) - w_e);
            end else if (r_busy) begin
                r_frac <= {r_frac[igfc_pkg::FRAC_W-2:0], w_t[igfc_pkg::WORD_W]};
                r_m    <= w_t[igfc_pkg::WORD_W] ? w_t[igfc_pkg::WORD_W:1]
                                                : w_t[igfc_pkg::WORD_W-1:0];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = {r_e, r_frac};

    // Start only on an idle unit
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("log2 started while busy");

endmodule

// ----- rtl/igfc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_div: restoring unsigned divider
// One quotient bit per cycle, 64-bit dividend by a 32-bit divisor.
// ----------------------------------------------------------------------------
module igfc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [igfc_pkg::ACC_W-1:0]  i_num,
    input  logic [igfc_pkg::WORD_W-1:0] i_den,
    output logic                        o_done,
    output logic [igfc_pkg::ACC_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(igfc_pkg::ACC_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [igfc_pkg::ACC_W-1:0]  r_num;
    logic [igfc_pkg::WORD_W-1:0] r_den;
    logic [igfc_pkg::WORD_W-1:0] r_rem;

    logic [igfc_pkg::WORD_W:0]   w_sh;
    logic                        w_ge;
    logic [igfc_pkg::WORD_W:0]   w_diff;

    assign w_sh   = {r_rem, r_num[igfc_pkg::ACC_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    // Shift, compare and subtract one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[igfc_pkg::WORD_W-1:0] : w_sh[igfc_pkg::WORD_W-1:0];
                r_num <= {r_num[igfc_pkg::ACC_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

    // Start only on an idle unit
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// ----- rtl/igfc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_dp: datapath of the information gain block
// Count stores, log2 unit, multiplier, accumulators, divider and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module igfc_dp #(
    parameter int MAX_LABELS      = igfc_pkg::MAX_LABELS_DEF,
    parameter int MAX_ATTR_VALUES = igfc_pkg::MAX_ATTR_VALUES_DEF,
    parameter int COUNT_BITS      = igfc_pkg::COUNT_BITS_DEF,
    localparam int LBL_AW = $clog2(MAX_LABELS),
    localparam int ATR_AW = $clog2(MAX_ATTR_VALUES),
    localparam int JNT_AW = $clog2(MAX_LABELS * MAX_ATTR_VALUES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  igfc_pkg::t_cmd              i_cmd,
    output igfc_pkg::t_stat             o_stat,
    input  logic [LBL_AW-1:0]           i_y,
    input  logic [ATR_AW-1:0]           i_x,
    input  logic [JNT_AW-1:0]           i_p,
    input  igfc_pkg::t_op               i_op,
    input  logic [igfc_pkg::IDX_W-1:0]  i_label_index,
    input  logic [igfc_pkg::IDX_W-1:0]  i_attr_index,
    input  logic [igfc_pkg::CNT_W-1:0]  i_count,
    input  logic [igfc_pkg::CNT_W-1:0]  i_total_instances,
    output logic [igfc_pkg::OUT_W-1:0]  o_mutual_information,
    output logic [igfc_pkg::OUT_W-1:0]  o_label_entropy,
    output logic [igfc_pkg::OUT_W-1:0]  o_conditional_entropy,
    output logic [igfc_pkg::ST_W-1:0]   o_status
);

    localparam int JNT_D = MAX_LABELS * MAX_ATTR_VALUES;
    localparam int PRD_W = COUNT_BITS + igfc_pkg::LOG_W + 2;

    // Stores
    logic [COUNT_BITS-1:0] r_lbl [MAX_LABELS];
    logic [COUNT_BITS-1:0] r_attr [MAX_ATTR_VALUES];
    logic [JNT_D-1:0]      r_jval;
    logic                  r_jv_q;
    logic [COUNT_BITS-1:0] r_a;
    logic [COUNT_BITS-1:0] w_jq;

    // Working registers
    logic                          r_nzero;
    logic                          r_st2;
    logic [COUNT_BITS-1:0]         r_n;
    logic [COUNT_BITS-1:0]         r_opnd;
    logic [igfc_pkg::LOG_W-1:0]    r_la;
    logic [igfc_pkg::LOG_W-1:0]    r_lb;
    logic [igfc_pkg::LOG_W-1:0]    r_ln;
    logic signed [igfc_pkg::ACC_W-1:0] r_prod;
    logic [igfc_pkg::ACC_W-1:0]    r_acc_s;
    logic signed [igfc_pkg::ACC_W-1:0] r_acc_c;
    logic [igfc_pkg::ACC_W-1:0]    r_q;
    logic [igfc_pkg::ACC_W-1:0]    r_hc;
    logic [igfc_pkg::OUT_W-1:0]    r_mi;
    logic [igfc_pkg::OUT_W-1:0]    r_le;
    logic [igfc_pkg::OUT_W-1:0]    r_ce;
    logic [igfc_pkg::ST_W-1:0]     r_status;

    logic [igfc_pkg::WORD_W-1:0]   w_cnt_w;
    logic [igfc_pkg::WORD_W-1:0]   w_n_w;
    logic [COUNT_BITS-1:0]         w_cnt;
    logic [COUNT_BITS-1:0]         w_n;
    logic                          w_li_ok;
    logic                          w_ai_ok;
    logic                          w_lbl_we;
    logic                          w_attr_we;
    logic                          w_jnt_we;
    logic [JNT_AW-1:0]             w_jaddr;
    logic [COUNT_BITS-1:0]         w_c;
    logic [COUNT_BITS-1:0]         w_v;
    logic [igfc_pkg::WORD_W-1:0]   w_log_x;
    logic                          w_log_done;
    logic [igfc_pkg::LOG_W-1:0]    w_log_r;
    logic signed [igfc_pkg::LOG_W:0] w_mulb;
    logic signed [PRD_W-1:0]       w_prod;
    logic [igfc_pkg::ACC_W-1:0]    w_div_num;
    logic                          w_div_done;
    logic [igfc_pkg::ACC_W-1:0]    w_quot;
    logic [igfc_pkg::ACC_W-1:0]    w_ln64;
    logic [igfc_pkg::ACC_W-1:0]    w_hl;
    logic [igfc_pkg::ACC_W-1:0]    w_mi;

    // Mask the load fields to the count width
    assign w_cnt_w  = igfc_pkg::WORD_W'(i_count);
    assign w_n_w    = igfc_pkg::WORD_W'(i_total_instances);
    assign w_cnt    = w_cnt_w[COUNT_BITS-1:0];
    assign w_n      = w_n_w[COUNT_BITS-1:0];
    assign w_li_ok  = int'(i_label_index) < MAX_LABELS;
    assign w_ai_ok  = int'(i_attr_index) < MAX_ATTR_VALUES;
    assign w_lbl_we = i_cmd.load && (i_op == igfc_pkg::OP_LABEL) && w_li_ok;
    assign w_attr_we = i_cmd.load && (i_op == igfc_pkg::OP_ATTR) && w_ai_ok;
    assign w_jnt_we = i_cmd.load && (i_op == igfc_pkg::OP_JOINT) && w_li_ok && w_ai_ok;
    assign w_jaddr  = JNT_AW'(int'(i_label_index) * MAX_ATTR_VALUES + int'(i_attr_index));

    // Label and attribute stores, joint valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_LABELS; i++) r_lbl[i] <= '0;
            for (int i = 0; i < MAX_ATTR_VALUES; i++) r_attr[i] <= '0;
            r_jval <= '0;
        end else begin
            if (w_lbl_we) r_lbl[LBL_AW'(i_label_index)] <= w_cnt;
            if (w_attr_we) r_attr[ATR_AW'(i_attr_index)] <= w_cnt;
            if (w_jnt_we) r_jval[w_jaddr] <= 1'b1;
        end
    end

    igfc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (JNT_D)
    ) u_joint (
        .i_clk   (i_clk),
        .i_we    (w_jnt_we),
        .i_waddr (w_jaddr),
        .i_wdata (w_cnt),
        .i_raddr (i_p),
        .o_rdata (w_jq)
    );

    // Fetch the valid bit and attribute count alongside the joint read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pair) begin
            r_jv_q <= r_jval[i_p];
            r_a    <= r_attr[i_x];
        end
    end

    assign w_v = r_jv_q ? w_jq : '0;
    assign w_c = r_lbl[i_y];

    // Log2 operand select
    always_comb begin
        case (i_cmd.log_src)
            igfc_pkg::SRC_LABEL: w_log_x = igfc_pkg::WORD_W'(w_c);
            igfc_pkg::SRC_TOTAL: w_log_x = igfc_pkg::WORD_W'(r_n);
            igfc_pkg::SRC_ATTR:  w_log_x = igfc_pkg::WORD_W'(r_a);
            default:             w_log_x = igfc_pkg::WORD_W'(w_v);
        endcase
    end

    igfc_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.log_start),
        .i_x      (w_log_x),
        .o_done   (w_log_done),
        .o_result (w_log_r)
    );

    // Multiplier operands
    assign w_mulb = i_cmd.mul_pair ? ($signed({1'b0, r_la}) - $signed({1'b0, r_lb}))
                                   : $signed({1'b0, r_lb});
    assign w_prod = $signed({1'b0, r_opnd}) * w_mulb;

    assign w_div_num = i_cmd.div_c ? $unsigned(r_acc_c) : r_acc_s;

    igfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (igfc_pkg::WORD_W'(r_n)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Final differences with clamping at zero
    assign w_ln64 = igfc_pkg::ACC_W'(r_ln);
    assign w_hl   = (w_ln64 > r_q) ? (w_ln64 - r_q) : '0;
    assign w_mi   = (w_hl > r_hc) ? (w_hl - r_hc) : '0;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nzero <= 1'b0;
            r_st2   <= 1'b0;
        end else if (i_cmd.latch_n) begin
            r_nzero <= (w_n == '0);
            r_st2   <= 1'b0;
        end else if (i_cmd.set_st2) begin
            r_st2 <= 1'b1;
        end
    end

    // Operands, accumulators and quotients
    always_ff @(posedge i_clk) begin
        r_prod <= igfc_pkg::ACC_W'(w_prod);
        if (i_cmd.latch_n) begin
            r_n     <= w_n;
            r_acc_s <= '0;
            r_acc_c <= '0;
        end
        if (i_cmd.cap_op) r_opnd <= i_cmd.mul_pair ? w_v : w_c;
        if (i_cmd.cap_la) r_la <= w_log_r;
        if (i_cmd.cap_lb) r_lb <= w_log_r;
        if (i_cmd.cap_ln) r_ln <= w_log_r;
        if (i_cmd.acc_s) r_acc_s <= r_acc_s + $unsigned(r_prod);
        if (i_cmd.acc_c) r_acc_c <= r_acc_c + r_prod;
        if (i_cmd.cap_q) r_q <= w_quot;
        if (i_cmd.cap_hc) r_hc <= w_quot;
        else if (i_cmd.zero_hc) r_hc <= '0;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_nzero) begin
                r_mi     <= '0;
                r_le     <= '0;
                r_ce     <= '0;
                r_status <= igfc_pkg::ST_ZERO_TOTAL;
            end else begin
                r_mi     <= igfc_pkg::sat_out(w_mi);
                r_le     <= igfc_pkg::sat_out(w_hl);
                r_ce     <= igfc_pkg::sat_out(r_hc);
                r_status <= r_st2 ? igfc_pkg::ST_NO_ATTR : igfc_pkg::ST_OK;
            end
        end
    end

    assign o_mutual_information  = r_mi;
    assign o_label_entropy       = r_le;
    assign o_conditional_entropy = r_ce;
    assign o_status              = r_status;

    assign o_stat.n_zero   = r_nzero;
    assign o_stat.lbl_nz   = (w_c != '0);
    assign o_stat.v_zero   = (w_v == '0);
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.log_done = w_log_done;
    assign o_stat.div_done = w_div_done;
    assign o_stat.c_pos    = !r_acc_c[igfc_pkg::ACC_W-1] && (r_acc_c != '0);

endmodule

// ----- rtl/igfc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfc_ctrl: controller of the information gain block
// Takes requests, sequences the label walk, the pair walk and the two
// divisions, and drives the result handshake.
// ----------------------------------------------------------------------------
module igfc_ctrl #(
    parameter int MAX_LABELS      = igfc_pkg::MAX_LABELS_DEF,
    parameter int MAX_ATTR_VALUES = igfc_pkg::MAX_ATTR_VALUES_DEF,
    localparam int LBL_AW = $clog2(MAX_LABELS),
    localparam int ATR_AW = $clog2(MAX_ATTR_VALUES),
    localparam int JNT_AW = $clog2(MAX_LABELS * MAX_ATTR_VALUES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  igfc_pkg::t_op     i_op,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output igfc_pkg::t_cmd    o_cmd,
    input  igfc_pkg::t_stat   i_stat,
    output logic [LBL_AW-1:0] o_y,
    output logic [ATR_AW-1:0] o_x,
    output logic [JNT_AW-1:0] o_p
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_L_RD, S_L_LOG, S_L_MUL, S_L_ACC, S_LN, S_S_DIV,
        S_P_RD, S_P_CHK, S_P_LA, S_P_LV, S_P_MUL, S_P_ACC, S_C_CHK, S_C_DIV,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [LBL_AW-1:0]  r_y, n_y;
    logic [ATR_AW-1:0]  r_x, n_x;
    logic [JNT_AW-1:0]  r_p, n_p;
    logic               r_out_valid, n_out_valid;
    logic               w_l_adv;
    logic               w_p_adv;
    logic               w_take;

    assign w_take = (r_state == S_IDLE) && i_in_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_y         = r_y;
        n_x         = r_x;
        n_p         = r_p;
        n_out_valid = r_out_valid && !i_out_ready;
        w_l_adv     = 1'b0;
        w_p_adv     = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_op == igfc_pkg::OP_COMPUTE) begin
                        o_cmd.latch_n = 1'b1;
                        n_state       = S_START;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_START: begin
                n_y     = '0;
                n_state = i_stat.n_zero ? S_EMIT : S_L_RD;
            end
            S_L_RD: begin
                if (i_stat.lbl_nz) begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_src   = igfc_pkg::SRC_LABEL;
                    o_cmd.cap_op    = 1'b1;
                    n_state         = S_L_LOG;
                end else begin
                    w_l_adv = 1'b1;
                end
            end
            S_L_LOG: begin
                if (i_stat.log_done) begin
                    o_cmd.cap_lb = 1'b1;
                    n_state      = S_L_MUL;
                end
            end
            S_L_MUL: n_state = S_L_ACC;
            S_L_ACC: begin
                o_cmd.acc_s = 1'b1;
                w_l_adv     = 1'b1;
            end
            S_LN: begin
                o_cmd.log_src = igfc_pkg::SRC_TOTAL;
                if (i_stat.log_done) begin
                    o_cmd.cap_ln    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_S_DIV;
                end
            end
            S_S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_q = 1'b1;
                    n_p         = '0;
                    n_x         = '0;
                    n_state     = S_P_RD;
                end
            end
            S_P_RD: begin
                o_cmd.rd_pair = 1'b1;
                n_state       = S_P_CHK;
            end
            S_P_CHK: begin
                if (i_stat.v_zero) begin
                    w_p_adv = 1'b1;
                end else if (i_stat.a_zero) begin
                    o_cmd.set_st2 = 1'b1;
                    w_p_adv       = 1'b1;
                end else begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_src   = igfc_pkg::SRC_ATTR;
                    o_cmd.cap_op    = 1'b1;
                    o_cmd.mul_pair  = 1'b1;
                    n_state         = S_P_LA;
                end
            end
            S_P_LA: begin
                if (i_stat.log_done) begin
                    o_cmd.cap_la    = 1'b1;
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_src   = igfc_pkg::SRC_JOINT;
                    n_state         = S_P_LV;
                end
            end
            S_P_LV: begin
                if (i_stat.log_done) begin
                    o_cmd.cap_lb = 1'b1;
                    n_state      = S_P_MUL;
                end
            end
            S_P_MUL: begin
                o_cmd.mul_pair = 1'b1;
                n_state        = S_P_ACC;
            end
            S_P_ACC: begin
                o_cmd.acc_c = 1'b1;
                w_p_adv     = 1'b1;
            end
            // Conditional sum is complete here; divide only a positive one
            S_C_CHK: begin
                o_cmd.div_c = 1'b1;
                if (i_stat.c_pos) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_C_DIV;
                end else begin
                    o_cmd.zero_hc = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_C_DIV: begin
                o_cmd.div_c = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.cap_hc = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the label walk, then start log2 of the total
        if (w_l_adv) begin
            if (r_y == LBL_AW'(MAX_LABELS - 1)) begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_src   = igfc_pkg::SRC_TOTAL;
                n_state         = S_LN;
            end else begin
                n_y     = r_y + 1'b1;
                n_state = S_L_RD;
            end
        end

        // Advance the pair walk, then check the conditional sum
        if (w_p_adv) begin
            if (r_p == JNT_AW'(MAX_LABELS * MAX_ATTR_VALUES - 1)) begin
                n_state = S_C_CHK;
            end else begin
                n_p     = r_p + 1'b1;
                n_x     = (r_x == ATR_AW'(MAX_ATTR_VALUES - 1)) ? '0 : r_x + 1'b1;
                n_state = S_P_RD;
            end
        end
    end

    // State, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_y         <= '0;
            r_x         <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_y         <= n_y;
            r_x         <= n_x;
            r_p         <= n_p;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_y         = r_y;
    assign o_x         = r_x;
    assign o_p         = r_p;

    // A log2 result arrives only while the walk waits for it
    a_log_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.log_done |-> (r_state == S_L_LOG || r_state == S_LN ||
                             r_state == S_P_LA || r_state == S_P_LV))
        else $error("unexpected log2 completion");

    // A quotient arrives only while a division is awaited
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_S_DIV || r_state == S_C_DIV))
        else $error("unexpected divider completion");

    // Label index stays within the store
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_y) < MAX_LABELS)
        else $error("label index out of range");

endmodule

// ----- rtl/information_gain_from_counts.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// information_gain_from_counts: mutual information of a label and an attribute
// Loads label, attribute-value and joint counts, then on a compute request
// emits label entropy, conditional entropy and their difference in Q4.16.
// ----------------------------------------------------------------------------
// Load requests (label, attribute-value and joint counts) are taken while an
// earlier result still waits at the output. A compute request walks every
// label entry and every label/attribute pair through one shared log2 unit
// (16 squaring steps per logarithm) and one restoring divider (64 steps per
// quotient). The conditional division is skipped when the conditional sum is
// not positive, and a zero total goes straight to the result. After the
// result is loaded all stores read as zero again. Status reports a zero
// total, or a joint count whose attribute count is zero.
module information_gain_from_counts #(
    parameter int MAX_LABELS      = igfc_pkg::MAX_LABELS_DEF,
    parameter int MAX_ATTR_VALUES = igfc_pkg::MAX_ATTR_VALUES_DEF,
    parameter int COUNT_BITS      = igfc_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [igfc_pkg::OP_W-1:0]  i_operation,
    input  logic [igfc_pkg::IDX_W-1:0] i_label_index,
    input  logic [igfc_pkg::IDX_W-1:0] i_attr_index,
    input  logic [igfc_pkg::CNT_W-1:0] i_count,
    input  logic [igfc_pkg::CNT_W-1:0] i_total_instances,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [igfc_pkg::OUT_W-1:0] o_mutual_information,
    output logic [igfc_pkg::OUT_W-1:0] o_label_entropy,
    output logic [igfc_pkg::OUT_W-1:0] o_conditional_entropy,
    output logic [igfc_pkg::ST_W-1:0]  o_status
);

    localparam int LBL_AW = $clog2(MAX_LABELS);
    localparam int ATR_AW = $clog2(MAX_ATTR_VALUES);
    localparam int JNT_AW = $clog2(MAX_LABELS * MAX_ATTR_VALUES);

    igfc_pkg::t_cmd    w_cmd;
    igfc_pkg::t_stat   w_stat;
    igfc_pkg::t_op     w_op;
    logic [LBL_AW-1:0] w_y;
    logic [ATR_AW-1:0] w_x;
    logic [JNT_AW-1:0] w_p;

    assign w_op = igfc_pkg::t_op'(i_operation);

    igfc_ctrl #(
        .MAX_LABELS      (MAX_LABELS),
        .MAX_ATTR_VALUES (MAX_ATTR_VALUES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (w_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat),
        .o_y         (w_y),
        .o_x         (w_x),
        .o_p         (w_p)
    );

    igfc_dp #(
        .MAX_LABELS      (MAX_LABELS),
        .MAX_ATTR_VALUES (MAX_ATTR_VALUES),
        .COUNT_BITS      (COUNT_BITS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_y                   (w_y),
        .i_x                   (w_x),
        .i_p                   (w_p),
        .i_op                  (w_op),
        .i_label_index         (i_label_index),
        .i_attr_index          (i_attr_index),
        .i_count               (i_count),
        .i_total_instances     (i_total_instances),
        .o_mutual_information  (o_mutual_information),
        .o_label_entropy       (o_label_entropy),
        .o_conditional_entropy (o_conditional_entropy),
        .o_status              (o_status)
    );

endmodule
